// ===== rtl/accalu_pkg.sv =====
// ----------------------------------------------------------------------------
// accalu_pkg
// Shared widths, codes and control structures of the accumulator ALU.
// ----------------------------------------------------------------------------
package accalu_pkg;

	localparam int WIDTH_DEF = 8;
	localparam int FUNC_W    = 3;
	localparam int DATA_W    = 8;
	localparam int OP_W      = 4;

	typedef enum logic [FUNC_W-1:0] {
		FN_WR_A  = 3'd0,
		FN_WR_B  = 3'd1,
		FN_WR_OP = 3'd2,
		FN_RUN   = 3'd3,
		FN_RD_A  = 3'd4,
		FN_RD_B  = 3'd5,
		FN_RD_OP = 3'd6
	} accalu_func_t;

	localparam logic [OP_W-1:0] OPC_ADD = 4'd1;
	localparam logic [OP_W-1:0] OPC_SUB = 4'd2;
	localparam logic [OP_W-1:0] OPC_MUL = 4'd3;
	localparam logic [OP_W-1:0] OPC_DIV = 4'd4;
	localparam logic [OP_W-1:0] OPC_AND = 4'd5;
	localparam logic [OP_W-1:0] OPC_OR  = 4'd6;
	localparam logic [OP_W-1:0] OPC_NOT = 4'd7;
	localparam logic [OP_W-1:0] OPC_XOR = 4'd8;

	typedef struct packed {
		logic carry;
		logic zero;
		logic overflow;
		logic divzero;
		logic unknown;
	} accalu_flags_t;

	// Controller to datapath.
	typedef struct packed {
		logic accept;
		logic step;
		logic finish;
	} accalu_cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic iter_op;
	} accalu_sts_t;

endpackage

// ===== rtl/accalu_if.sv =====
// ----------------------------------------------------------------------------
// accalu_in_if / accalu_out_if
// Valid/ready channels carrying request items and result items.
// ----------------------------------------------------------------------------
interface accalu_in_if;
	logic                             valid;
	logic                             ready;
	logic [accalu_pkg::FUNC_W-1:0]    func;
	logic [accalu_pkg::DATA_W-1:0]    write_value;

	modport source(output valid, func, write_value, input ready);
	modport sink(input valid, func, write_value, output ready);
endinterface

interface accalu_out_if;
	logic                             valid;
	logic                             ready;
	logic [accalu_pkg::DATA_W-1:0]    read_data;
	logic                             carry;
	logic                             zero;
	logic                             overflow;
	logic                             divide_by_zero;
	logic                             unknown_op;

	modport source(output valid, read_data, carry, zero, overflow, divide_by_zero,
		unknown_op, input ready);
	modport sink(input valid, read_data, carry, zero, overflow, divide_by_zero,
		unknown_op, output ready);
endinterface

// ===== rtl/accalu_ctrl.sv =====
// ----------------------------------------------------------------------------
// accalu_ctrl
// Sequencer: handshakes, bit-step counter for multiply/divide, result valid.
// ----------------------------------------------------------------------------
module accalu_ctrl #(
	parameter int WIDTH = accalu_pkg::WIDTH_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     req_valid,
	output logic                     req_ready,
	output logic                     rsp_valid,
	input  logic                     rsp_ready,
	input  accalu_pkg::accalu_sts_t  sts,
	output accalu_pkg::accalu_cmd_t  cmd
);

	localparam int CW = $clog2(WIDTH);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_ITER = 3'b010,
		ST_FIN  = 3'b100
	} state_t;

	state_t          state_q;
	logic [CW-1:0]   cnt_q;
	logic            out_valid_q;
	logic            accept;
	logic            commit;

	assign req_ready = (state_q == ST_IDLE) && (!out_valid_q || rsp_ready);
	assign accept    = req_valid && req_ready;
	assign commit    = (accept && !sts.iter_op) || (state_q == ST_FIN);
	assign rsp_valid = out_valid_q;

	assign cmd.accept = accept;
	assign cmd.step   = (state_q == ST_ITER);
	assign cmd.finish = (state_q == ST_FIN);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept && sts.iter_op) begin
						state_q <= ST_ITER;
						cnt_q   <= CW'(WIDTH - 1);
					end
				end
				ST_ITER: begin
					if (cnt_q == '0) begin
						state_q <= ST_FIN;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				ST_FIN: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			if (commit) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// A multiply or divide run delivers its result after the accept, a step per bit
	// and the finish state.
	a_iter_latency: assert property (@(posedge clk) disable iff (!arst_n)
		accept && sts.iter_op |-> ##(WIDTH + 2) out_valid_q)
		else $error("iterative run did not produce a result in time");

	// A new result never overwrites one that has not been transferred.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		commit |-> !out_valid_q || rsp_ready)
		else $error("result register overwritten before transfer");

	a_finish_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> (state_q == ST_IDLE) && out_valid_q)
		else $error("finish did not return to idle with a valid result");

endmodule

// ===== rtl/accalu_dp.sv =====
// ----------------------------------------------------------------------------
// accalu_dp
// Register file, flags, adder/logic unit and the shared shift-add /
// restoring-divide unit that retires one bit per step.
// ----------------------------------------------------------------------------
module accalu_dp #(
	parameter int WIDTH = accalu_pkg::WIDTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  accalu_pkg::accalu_cmd_t          cmd,
	output accalu_pkg::accalu_sts_t          sts,
	input  logic [accalu_pkg::FUNC_W-1:0]    func,
	input  logic [accalu_pkg::DATA_W-1:0]    write_value,
	output logic [accalu_pkg::DATA_W-1:0]    read_data,
	output logic                             carry,
	output logic                             zero,
	output logic                             overflow,
	output logic                             divide_by_zero,
	output logic                             unknown_op
);

	localparam logic [WIDTH-1:0] SIGN = {1'b1, {(WIDTH - 1){1'b0}}};
	localparam logic [WIDTH-1:0] SMAX = ~SIGN;

	logic [WIDTH-1:0]                      acc_q, b_q, op_q;
	accalu_pkg::accalu_flags_t             flags_q;
	logic [WIDTH-1:0]                      hi_q, lo_q;
	logic [accalu_pkg::DATA_W-1:0]         out_data_q;
	accalu_pkg::accalu_flags_t             out_flags_q;

	accalu_pkg::accalu_func_t              fn;
	logic [WIDTH+accalu_pkg::DATA_W-1:0]   wr_ext;
	logic [WIDTH-1:0]                      wr_val;
	logic [WIDTH-1:0]                      ma, mb;
	logic                                  neg;
	logic                                  op_ok;
	logic [accalu_pkg::OP_W-1:0]           op_code;
	logic                                  is_mul, is_div;
	logic [WIDTH-1:0]                      addend;
	logic [WIDTH:0]                        sum;
	logic                                  v_add, v_sub;
	logic                                  mul_ovf;
	logic [WIDTH-1:0]                      run_r;
	accalu_pkg::accalu_flags_t             run_f;
	logic [WIDTH-1:0]                      acc_nx, b_nx, op_nx;
	accalu_pkg::accalu_flags_t             flags_nx;
	logic                                  commit;
	logic [WIDTH-1:0]                      sel;
	logic [WIDTH+accalu_pkg::DATA_W-1:0]   sel_ext;
	logic [WIDTH:0]                        step_sum;
	logic [WIDTH-1:0]                      div_sh;
	logic [WIDTH:0]                        div_diff;

	assign fn     = accalu_pkg::accalu_func_t'(func);
	assign wr_ext = {{WIDTH{1'b0}}, write_value};
	assign wr_val = wr_ext[WIDTH-1:0];

	assign ma  = acc_q[WIDTH-1] ? (~acc_q + 1'b1) : acc_q;
	assign mb  = b_q[WIDTH-1] ? (~b_q + 1'b1) : b_q;
	assign neg = (acc_q[WIDTH-1] && !b_q[WIDTH-1] && (|b_q)) ||
		(!acc_q[WIDTH-1] && (|acc_q) && b_q[WIDTH-1]);

	// The opcode is taken as a signed number; only 1..8 are defined.
	assign op_ok   = ((op_q >> accalu_pkg::OP_W) == '0) && !op_q[WIDTH-1];
	assign op_code = op_q[accalu_pkg::OP_W-1:0];
	assign is_mul  = op_ok && (op_code == accalu_pkg::OPC_MUL);
	assign is_div  = op_ok && (op_code == accalu_pkg::OPC_DIV);

	assign sts.iter_op = (fn == accalu_pkg::FN_RUN) && (is_mul || is_div);

	assign addend = (op_code == accalu_pkg::OPC_SUB) ? (~b_q + 1'b1) : b_q;
	assign sum    = {1'b0, acc_q} + {1'b0, addend};
	assign v_add  = (acc_q[WIDTH-1] == b_q[WIDTH-1]) && (sum[WIDTH-1] != acc_q[WIDTH-1]);
	assign v_sub  = (acc_q[WIDTH-1] != b_q[WIDTH-1]) && (sum[WIDTH-1] != acc_q[WIDTH-1]);

	// The full magnitude product sits in {hi_q, lo_q} at finish.
	assign mul_ovf = (hi_q != '0) || (lo_q > (neg ? SIGN : SMAX));

	always_comb begin
		logic [WIDTH-1:0] mag;
		logic             use_sign;
		run_r    = acc_q;
		run_f    = '0;
		mag      = '0;
		use_sign = 1'b0;
		if (cmd.finish) begin
			if (is_mul) begin
				run_f.overflow = mul_ovf;
				if (b_q == '0) begin
					run_f.zero = 1'b1;
				end else begin
					mag        = lo_q;
					// Carry of the last repeated addition: it wrapped below ma.
					run_f.carry = (lo_q < ma);
					run_f.zero  = (lo_q == '0);
				end
				run_r    = mag;
				use_sign = neg;
			end else begin
				if (b_q == '0) begin
					run_f.divzero = 1'b1;
				end else begin
					mag            = lo_q;
					run_f.zero     = (lo_q == '0);
					run_f.overflow = (acc_q == SIGN) && (&b_q);
					run_r          = mag;
					use_sign       = neg;
				end
			end
		end else if (!op_ok) begin
			run_f.unknown = 1'b1;
		end else begin
			case (op_code)
				accalu_pkg::OPC_ADD: begin
					run_r          = sum[WIDTH-1:0];
					run_f.carry    = sum[WIDTH];
					run_f.zero     = (sum[WIDTH-1:0] == '0);
					run_f.overflow = v_add;
				end
				accalu_pkg::OPC_SUB: begin
					run_r          = sum[WIDTH-1:0];
					run_f.carry    = sum[WIDTH];
					run_f.zero     = (sum[WIDTH-1:0] == '0);
					run_f.overflow = v_sub;
				end
				accalu_pkg::OPC_AND: run_r = acc_q & b_q;
				accalu_pkg::OPC_OR:  run_r = acc_q | b_q;
				accalu_pkg::OPC_NOT: run_r = ~acc_q;
				accalu_pkg::OPC_XOR: run_r = acc_q ^ b_q;
				default:             run_f.unknown = 1'b1;
			endcase
		end
		// Negation is one more addition of +1, which sets carry and zero alike.
		if (use_sign) begin
			run_f.carry = (mag == '0);
			run_f.zero  = (mag == '0);
			run_r       = ~mag + 1'b1;
		end
		if (run_r[WIDTH-1]) begin
			run_f.carry = 1'b0;
			run_f.zero  = 1'b0;
		end
	end

	always_comb begin
		acc_nx   = acc_q;
		b_nx     = b_q;
		op_nx    = op_q;
		flags_nx = flags_q;
		commit   = 1'b0;
		if (cmd.finish) begin
			acc_nx   = run_r;
			flags_nx = run_f;
			commit   = 1'b1;
		end else if (cmd.accept && !sts.iter_op) begin
			commit = 1'b1;
			case (fn)
				accalu_pkg::FN_WR_A:  acc_nx = wr_val;
				accalu_pkg::FN_WR_B:  b_nx   = wr_val;
				accalu_pkg::FN_WR_OP: op_nx  = wr_val;
				accalu_pkg::FN_RUN: begin
					acc_nx   = run_r;
					flags_nx = run_f;
				end
				default: ;
			endcase
		end
	end

	always_comb begin
		sel = acc_nx;
		if (!cmd.finish) begin
			case (fn)
				accalu_pkg::FN_RD_B:  sel = b_q;
				accalu_pkg::FN_RD_OP: sel = op_q;
				default:              sel = acc_nx;
			endcase
		end
	end
	assign sel_ext = {{accalu_pkg::DATA_W{1'b0}}, sel};

	// One multiplier bit (shift-add) or one quotient bit (restoring) per step.
	assign step_sum = {1'b0, hi_q} + {1'b0, (lo_q[0] ? ma : {WIDTH{1'b0}})};
	assign div_sh   = {hi_q[WIDTH-2:0], lo_q[WIDTH-1]};
	assign div_diff = {1'b0, div_sh} - {1'b0, mb};

	always_ff @(posedge clk) begin
		if (cmd.accept && sts.iter_op) begin
			hi_q <= '0;
			lo_q <= is_mul ? mb : ma;
		end else if (cmd.step) begin
			if (is_mul) begin
				hi_q <= step_sum[WIDTH:1];
				lo_q <= {step_sum[0], lo_q[WIDTH-1:1]};
			end else if (!div_diff[WIDTH]) begin
				hi_q <= div_diff[WIDTH-1:0];
				lo_q <= {lo_q[WIDTH-2:0], 1'b1};
			end else begin
				hi_q <= div_sh;
				lo_q <= {lo_q[WIDTH-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q   <= '0;
			b_q     <= '0;
			op_q    <= '0;
			flags_q <= '0;
		end else begin
			acc_q   <= acc_nx;
			b_q     <= b_nx;
			op_q    <= op_nx;
			flags_q <= flags_nx;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			out_data_q  <= sel_ext[accalu_pkg::DATA_W-1:0];
			out_flags_q <= flags_nx;
		end
	end

	assign read_data      = out_data_q;
	assign carry          = out_flags_q.carry;
	assign zero           = out_flags_q.zero;
	assign overflow       = out_flags_q.overflow;
	assign divide_by_zero = out_flags_q.divzero;
	assign unknown_op     = out_flags_q.unknown;

endmodule

// ===== rtl/accumulator_alu_8bit_core.sv =====
// ----------------------------------------------------------------------------
// accumulator_alu_8bit_core
// Accumulator ALU with flags, driven by register write/read/run requests.
// ----------------------------------------------------------------------------
// Every request returns exactly one response, in order. Writes, reads, the
// undefined function code, and runs of add, subtract, the logic operations or
// an unknown opcode finish in the cycle of their request transfer: the response
// register loads at that edge and can transfer at the next one, so with a ready
// receiver these items go through at one per cycle. A multiply or divide run
// occupies the shared shift-add / restoring-divide unit for a step per bit and
// then a finish state; its response register loads as the finish state ends,
// and the next request is taken no earlier than that edge. A new request is
// taken when the sequencer is idle and the response register is empty or
// being emptied in the same cycle.
module accumulator_alu_8bit_core #(
	parameter int WIDTH = accalu_pkg::WIDTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	accalu_in_if.sink     req,
	accalu_out_if.source  rsp
);

	accalu_pkg::accalu_cmd_t  cmd;
	accalu_pkg::accalu_sts_t  sts;

	accalu_ctrl #(
		.WIDTH(WIDTH)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	accalu_dp #(
		.WIDTH(WIDTH)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.func           (req.func),
		.write_value    (req.write_value),
		.read_data      (rsp.read_data),
		.carry          (rsp.carry),
		.zero           (rsp.zero),
		.overflow       (rsp.overflow),
		.divide_by_zero (rsp.divide_by_zero),
		.unknown_op     (rsp.unknown_op)
	);

endmodule
